>>> rtl/base58_encoder_unit_macros.svh
// Assertion macros for the Base58 encoder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BASE58_ENCODER_UNIT_MACROS_SVH
`define BASE58_ENCODER_UNIT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define B58E_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("b58e check failed");

// Consequent holds in the same cycle as the antecedent.
`define B58E_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("b58e check failed");

// Consequent holds in the cycle after the antecedent.
`define B58E_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("b58e check failed");

`endif

>>> rtl/b58e_pkg.sv
// Shared constants, types and tables for the Base58 encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package b58e_pkg;

   localparam int MAX_BYTES_DEF   = 32;
   localparam int DIGIT_SLOTS_DEF = 45;
   localparam int OUT_LIMIT       = 45;
   localparam int RADIX           = 58;
   localparam int BYTE_RANGE      = 256;
   localparam int MAX_QUOT        = 5;

   localparam int BYTE_W    = 8;
   localparam int DIGIT_W   = 6;
   localparam int CARRY_W   = 9;
   localparam int SUM_W     = 9;
   localparam int QUOT_W    = $clog2(MAX_QUOT + 1);
   localparam int SYM_W     = 7;
   localparam int OUT_CNT_W = $clog2(OUT_LIMIT + 1);
   localparam int DIGIT_CODES = 2 ** DIGIT_W;

   localparam logic [RADIX*8-1:0] ALPHABET =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   // 256*d split as RADIX*quot + rem, per digit value
   typedef struct packed {
      logic [CARRY_W-1:0] quot;
      logic [DIGIT_W-1:0] rem;
   } mul_entry_type;

   typedef mul_entry_type [DIGIT_CODES-1:0] mul_tab_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [CARRY_W-1:0] carry;
   } fold_out_type;

   function automatic mul_tab_type build_mul_tab();
      mul_tab_type tab;
      for (int i = 0; i < DIGIT_CODES; i++) begin
         tab[i].quot = CARRY_W'((i * BYTE_RANGE) / RADIX);
         tab[i].rem  = DIGIT_W'((i * BYTE_RANGE) % RADIX);
      end
      return tab;
   endfunction

   localparam mul_tab_type MUL_TAB = build_mul_tab();

   function automatic logic [SYM_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] idx;
      idx = (d > DIGIT_W'(RADIX - 1)) ? DIGIT_W'(RADIX - 1) : d;
      return SYM_W'(ALPHABET[(RADIX - 1 - int'(idx))*8 +: 8]);
   endfunction

endpackage

>>> rtl/b58e_digit_ram.sv
// Digit store: one write port, one registered read port.
// Depends on b58e_pkg.
`timescale 1ns / 1ps

module b58e_digit_ram #(
   parameter int DEPTH = b58e_pkg::DIGIT_SLOTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH)-1:0]               wr_addr,
   input  logic [b58e_pkg::DIGIT_W-1:0]           wr_data,
   input  logic                                   rd_en,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr,
   output logic [b58e_pkg::DIGIT_W-1:0]           rd_data
);
   import b58e_pkg::*;

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/b58e_fold_alu.sv
// One digit step of the fold: digit*256 + carry split into new digit and carry.
// Depends on b58e_pkg (product table, result struct).
`timescale 1ns / 1ps

module b58e_fold_alu (
   input  logic [b58e_pkg::DIGIT_W-1:0]  digit_val,
   input  logic [b58e_pkg::CARRY_W-1:0]  carry_val,
   output b58e_pkg::fold_out_type        result
);
   import b58e_pkg::*;

   always_comb begin
      mul_entry_type       ent;
      logic [SUM_W-1:0]    sum;
      logic [QUOT_W-1:0]   qq;
      ent = MUL_TAB[digit_val];
      sum = SUM_W'(ent.rem) + carry_val;
      qq  = '0;
      for (int k = 1; k <= MAX_QUOT; k++) begin
         if (sum >= SUM_W'(k * RADIX)) begin
            qq = qq + QUOT_W'(1);
         end
      end
      result.digit = DIGIT_W'(sum - SUM_W'(int'(qq) * RADIX));
      result.carry = ent.quot + CARRY_W'(qq);
   end

endmodule

>>> rtl/base58_encoder_unit.sv
// Base58 encoder top level: control sequencer around the digit store.
// Depends on b58e_pkg, b58e_digit_ram, b58e_fold_alu and the macros header.
//
//  channel | dir | tdata                   | tlast       | tuser
//  req     | in  | [7:0] data_byte         | last_byte   | -
//  rsp     | out | [6:0] symbol, [7] zero  | end_of_run  | overflow
//
// A leading-zero or dropped byte is taken in ST_IDLE alone; any other byte
// passes ST_FOLD_RD, then ST_FOLD walks one digit per cycle (up to DIGIT_SLOTS)
// through the store's read port with the read for the next digit in flight.
// A '1' prefix passes ST_EMIT_RD, ST_EMIT_OUT; a digit adds ST_EMIT_LD (one read).
// Reset is synchronous; no clearing pass, the used-digit count masks stale
// store entries. A stalled rsp holds the sequencer; req is refused meanwhile.
`timescale 1ns / 1ps
`include "base58_encoder_unit_macros.svh"

module base58_encoder_unit #(
   parameter int MAX_BYTES   = b58e_pkg::MAX_BYTES_DEF,
   parameter int DIGIT_SLOTS = b58e_pkg::DIGIT_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] symbol, [7] zero fill
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] overflow
);
   import b58e_pkg::*;

   localparam int AW = $clog2(DIGIT_SLOTS);
   localparam int JW = $clog2(DIGIT_SLOTS + 1);
   localparam int LW = $clog2(MAX_BYTES + 1);
   localparam int TW = $clog2(MAX_BYTES + DIGIT_SLOTS + OUT_LIMIT + 1);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
   localparam logic [ST_W-1:0] ST_FOLD_RD  = 3'd1;
   localparam logic [ST_W-1:0] ST_FOLD     = 3'd2;
   localparam logic [ST_W-1:0] ST_EMIT_RD  = 3'd3;
   localparam logic [ST_W-1:0] ST_EMIT_LD  = 3'd4;
   localparam logic [ST_W-1:0] ST_EMIT_OUT = 3'd5;

   logic [ST_W-1:0]      state_ff, state_in;
   logic [JW-1:0]        used_ff, used_in;
   logic [LW-1:0]        lz_ff, lz_in;
   logic                 nz_ff, nz_in;
   logic [LW-1:0]        taken_ff, taken_in;
   logic                 ovf_ff, ovf_in;
   logic                 last_ff, last_in;
   logic [JW-1:0]        jj_ff, jj_in;
   logic [OUT_CNT_W-1:0] k_ff, k_in;
   logic [JW-1:0]        dptr_ff, dptr_in;
   logic [CARRY_W-1:0]   carry_ff, carry_in;
   logic [SYM_W-1:0]     sym_ff, sym_in;

   logic [TW-1:0]        total;
   logic [OUT_CNT_W-1:0] count;
   logic                 ovf_out;
   logic                 end_flag;
   logic                 in_lz;

   logic                 in_range, carry_nz, at_end, active;
   logic [JW-1:0]        jj_next, new_used;
   logic [DIGIT_W-1:0]   fold_digit;
   fold_out_type         alu_out;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [DIGIT_W-1:0]   ram_rdata;
   logic                 dptr_path;

   b58e_digit_ram #(
      .DEPTH(DIGIT_SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(alu_out.digit),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   b58e_fold_alu u_alu (
      .digit_val(fold_digit),
      .carry_val(carry_ff),
      .result   (alu_out)
   );

   assign total    = TW'(lz_ff) + TW'(used_ff);
   assign count    = (total > TW'(OUT_LIMIT)) ? OUT_CNT_W'(OUT_LIMIT) : OUT_CNT_W'(total);
   assign ovf_out  = ovf_ff || (total > TW'(OUT_LIMIT));
   assign end_flag = (k_ff + OUT_CNT_W'(1)) == count;
   assign in_lz    = TW'(k_ff) < TW'(lz_ff);

   assign in_range   = jj_ff < used_ff;
   assign carry_nz   = carry_ff != '0;
   assign at_end     = jj_ff == JW'(DIGIT_SLOTS);
   assign active     = !at_end && (in_range || carry_nz);
   assign jj_next    = jj_ff + JW'(1);
   assign new_used   = (jj_ff > used_ff) ? jj_ff : used_ff;
   assign fold_digit = in_range ? ram_rdata : '0;

   assign dptr_path = (state_ff == ST_EMIT_RD) && (k_ff < count) && !in_lz;

   always_comb begin
      ram_we    = (state_ff == ST_FOLD) && active;
      ram_waddr = jj_ff[AW-1:0];
      ram_re    = 1'b0;
      ram_raddr = '0;
      case (state_ff)
         ST_FOLD_RD: begin
            ram_re = 1'b1;
         end
         ST_FOLD: begin
            ram_re    = active && (jj_next < JW'(DIGIT_SLOTS));
            ram_raddr = jj_next[AW-1:0];
         end
         ST_EMIT_RD: begin
            ram_re    = dptr_path;
            ram_raddr = AW'(dptr_ff - JW'(1));
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      lz_in    = lz_ff;
      nz_in    = nz_ff;
      taken_in = taken_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      jj_in    = jj_ff;
      k_in     = k_ff;
      dptr_in  = dptr_ff;
      carry_in = carry_ff;
      sym_in   = sym_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               last_in = req_tlast;
               k_in    = '0;
               dptr_in = used_ff;
               if (taken_ff < LW'(MAX_BYTES)) begin
                  taken_in = taken_ff + LW'(1);
                  if (req_tdata == '0 && !nz_ff) begin
                     lz_in    = lz_ff + LW'(1);
                     state_in = req_tlast ? ST_EMIT_RD : ST_IDLE;
                  end else begin
                     nz_in    = 1'b1;
                     carry_in = CARRY_W'(req_tdata);
                     jj_in    = '0;
                     state_in = ST_FOLD_RD;
                  end
               end else begin
                  ovf_in   = 1'b1;
                  state_in = req_tlast ? ST_EMIT_RD : ST_IDLE;
               end
            end
         end
         ST_FOLD_RD: begin
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (active) begin
               carry_in = alu_out.carry;
               jj_in    = jj_next;
            end else begin
               if (at_end && carry_nz) begin
                  ovf_in = 1'b1;
               end
               used_in  = new_used;
               k_in     = '0;
               dptr_in  = new_used;
               state_in = last_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            if (k_ff >= count) begin
               used_in  = '0;
               lz_in    = '0;
               nz_in    = 1'b0;
               taken_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else if (in_lz) begin
               sym_in   = digit_symbol('0);
               state_in = ST_EMIT_OUT;
            end else begin
               dptr_in  = dptr_ff - JW'(1);
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            sym_in   = digit_symbol(ram_rdata);
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_tready) begin
               if (end_flag) begin
                  used_in  = '0;
                  lz_in    = '0;
                  nz_in    = 1'b0;
                  taken_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + OUT_CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         lz_ff    <= '0;
         nz_ff    <= 1'b0;
         taken_ff <= '0;
         ovf_ff   <= 1'b0;
         last_ff  <= 1'b0;
         jj_ff    <= '0;
         k_ff     <= '0;
         dptr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         lz_ff    <= lz_in;
         nz_ff    <= nz_in;
         taken_ff <= taken_in;
         ovf_ff   <= ovf_in;
         last_ff  <= last_in;
         jj_ff    <= jj_in;
         k_ff     <= k_in;
         dptr_ff  <= dptr_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      sym_ff   <= sym_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_EMIT_OUT;
   assign rsp_tdata  = {1'b0, sym_ff};
   assign rsp_tlast  = end_flag;
   assign rsp_tuser  = ovf_out;

   `B58E_ASSERT_IMPLY(a_digit_range, clock, reset, ram_we, alu_out.digit < DIGIT_W'(RADIX))
   `B58E_ASSERT_IMPLY(a_carry_bound, clock, reset, state_ff == ST_FOLD, carry_ff <= CARRY_W'(BYTE_RANGE))
   `B58E_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= JW'(DIGIT_SLOTS))
   `B58E_ASSERT_IMPLY(a_emit_count, clock, reset, rsp_tvalid, k_ff < count)
   `B58E_ASSERT_NEXT(a_run_clear, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, state_ff == ST_IDLE && used_ff == '0 && taken_ff == '0)

endmodule

>>> sim/base58_encoder_checker.sv
// Stream checker for base58_encoder_unit: predicts the Base58 text of each message
// from the request words and compares every response word against it.
// Depends on b58e_pkg for widths and default sizes.
`timescale 1ns / 1ps

module base58_encoder_checker #(
   parameter int MAX_BYTES   = b58e_pkg::MAX_BYTES_DEF,
   parameter int DIGIT_SLOTS = b58e_pkg::DIGIT_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [6:0] symbol, [7] zero fill
   input  logic       rsp_tlast,
   input  logic       rsp_tuser,   // [0] overflow
   output int         error_count,
   output int         symbols_pending
);

   localparam int RADIX     = b58e_pkg::RADIX;
   localparam int OUT_LIMIT = b58e_pkg::OUT_LIMIT;
   localparam int SYM_W     = b58e_pkg::SYM_W;
   localparam int DIGIT_W   = b58e_pkg::DIGIT_W;
   localparam bit [8*58-1:0] SYMBOL_CHARS =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             end_of_run;
      logic             overflow;
   } symbol_word_type;

   logic [DIGIT_W-1:0] digits [DIGIT_SLOTS];
   int              digits_used;
   int              lead_zeros;
   int              bytes_taken;
   bit              nonzero_seen;
   bit              dropped_seen;
   int              mismatches = 0;
   symbol_word_type symbols_due [$];

   function automatic logic [SYM_W-1:0] digit_char(input int d);
      int idx;
      idx = (d > RADIX - 1) ? RADIX - 1 : d;
      return SYMBOL_CHARS[(RADIX - 1 - idx)*8 +: SYM_W];
   endfunction

   task automatic clear_number();
      foreach (digits[i]) digits[i] = '0;
      digits_used  = 0;
      lead_zeros   = 0;
      bytes_taken  = 0;
      nonzero_seen = 1'b0;
      dropped_seen = 1'b0;
   endtask

   // multiply the stored number by 256 and add the byte
   task automatic fold_byte(input int b);
      int carry;
      int j;
      int v;
      carry = b;
      j = 0;
      while (j < DIGIT_SLOTS && !(j >= digits_used && carry == 0)) begin
         v         = int'(digits[j]) * 256 + carry;
         digits[j] = DIGIT_W'(v % RADIX);
         carry     = v / RADIX;
         j++;
      end
      if (j > digits_used) digits_used = j;
      if (carry != 0) dropped_seen = 1'b1;
   endtask

   task automatic push_symbol(input logic [SYM_W-1:0] sym, input bit at_end, input bit ovf);
      symbol_word_type w;
      w.symbol     = sym;
      w.end_of_run = at_end;
      w.overflow   = ovf;
      symbols_due.push_back(w);
   endtask

   task automatic encode_word(input logic [7:0] b, input logic at_last);
      int total;
      int count;
      int k;
      bit ovf;
      if (bytes_taken < MAX_BYTES) begin
         bytes_taken++;
         if (b == 8'd0 && !nonzero_seen) begin
            lead_zeros++;
         end else begin
            nonzero_seen = 1'b1;
            fold_byte(int'(b));
         end
      end else begin
         dropped_seen = 1'b1;
      end
      if (at_last) begin
         total = lead_zeros + digits_used;
         ovf   = dropped_seen || total > OUT_LIMIT;
         count = (total > OUT_LIMIT) ? OUT_LIMIT : total;
         k = 0;
         for (int i = 0; i < lead_zeros && k < count; i++) begin
            push_symbol(digit_char(0), k + 1 == count, ovf);
            k++;
         end
         for (int i = digits_used; i > 0 && k < count; i--) begin
            push_symbol(digit_char(int'(digits[i-1])), k + 1 == count, ovf);
            k++;
         end
         clear_number();
      end
   endtask

   task automatic check_symbol();
      symbol_word_type due;
      if (symbols_due.size() == 0) begin
         $error("rsp word with nothing due: symbol %0d", rsp_tdata[SYM_W-1:0]);
         mismatches++;
      end else begin
         due = symbols_due.pop_front();
         if (rsp_tdata[SYM_W-1:0] !== due.symbol) begin
            $error("symbol: expected %0d, actual %0d", due.symbol, rsp_tdata[SYM_W-1:0]);
            mismatches++;
         end
         if (rsp_tdata[7] !== 1'b0) begin
            $error("zero fill: expected 0, actual %b", rsp_tdata[7]);
            mismatches++;
         end
         if (rsp_tlast !== due.end_of_run) begin
            $error("end_of_run: expected %0d, actual %b", due.end_of_run, rsp_tlast);
            mismatches++;
         end
         if (rsp_tuser !== due.overflow) begin
            $error("overflow: expected %0d, actual %b", due.overflow, rsp_tuser);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_number();
         symbols_due.delete();
      end else begin
         if (req_tvalid && req_tready) encode_word(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_symbol();
      end
      error_count     <= mismatches;
      symbols_pending <= symbols_due.size();
   end

endmodule

>>> sim/tb_base58_encoder_unit.sv
// Testbench top for base58_encoder_unit: drives messages with random idling and
// back-pressure, and reports the verdict from base58_encoder_checker.
// Depends on b58e_pkg, base58_encoder_unit and base58_encoder_checker.
`timescale 1ns / 1ps

module tb_base58_encoder_unit;

   localparam int ITEM_TARGET    = 500;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 100;
   localparam int MAX_BYTES      = b58e_pkg::MAX_BYTES_DEF;

   localparam int PHASE_FREE       = 0;
   localparam int PHASE_SEND_IDLE  = 1;
   localparam int PHASE_RECV_STALL = 2;
   localparam int PHASE_BOTH       = 3;

   localparam int MSG_RANDOM   = 0;
   localparam int MSG_ALL_MAX  = 1;
   localparam int MSG_ALL_ZERO = 2;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] data_byte
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [6:0] symbol, [7] zero fill
   logic       rsp_tlast;
   logic       rsp_tuser;   // [0] overflow

   int error_count;
   int symbols_pending;
   int send_idle_pct;
   int recv_stall_pct;
   int items_sent;
   int stalled_cycles = 0;

   base58_encoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   base58_encoder_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .error_count     (error_count),
      .symbols_pending (symbols_pending)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic set_phase(input int phase);
      case (phase)
         PHASE_SEND_IDLE: begin
            send_idle_pct  = 57;
            recv_stall_pct = 0;
         end
         PHASE_RECV_STALL: begin
            send_idle_pct  = 0;
            recv_stall_pct = 57;
         end
         PHASE_BOTH: begin
            send_idle_pct  = 19;
            recv_stall_pct = 19;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input logic [7:0] b, input logic at_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tlast  <= 1'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= at_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (symbols_pending != 0) @(negedge clock);
   endtask

   task automatic send_message(input int len, input int mode, input int zeros);
      logic [7:0] b;
      int pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 9);
         if (mode == MSG_ALL_MAX) begin
            b = (i < zeros) ? 8'h00 : 8'hFF;
         end else if (mode == MSG_ALL_ZERO || i < zeros) begin
            b = 8'h00;
         end else if (pick == 0) begin
            b = 8'hFF;
         end else if (pick == 1) begin
            b = 8'h00;
         end else begin
            b = 8'($urandom);
         end
         send_word(b, i == len - 1);
      end
   endtask

   initial begin
      int msg_no;
      int roll;
      int len;
      int zeros;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      req_tlast      = 1'b0;
      items_sent     = 0;
      msg_no         = 0;
      set_phase(PHASE_FREE);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single bytes at the extremes and around the radix
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
      send_word(8'h01, 1'b1);
      send_word(8'd57, 1'b1);
      send_word(8'd58, 1'b1);
      // all-zero message, leading zeros ahead of a number, inner zero
      send_message(3, MSG_ALL_ZERO, 0);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h01, 1'b1);
      send_word(8'h80, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h7F, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         set_phase((msg_no / 6) % 4);
         roll  = $urandom_range(0, 99);
         zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         if (roll < 60) begin
            len = $urandom_range(1, 8);
            send_message(len, MSG_RANDOM, zeros);
         end else if (roll < 80) begin
            len = $urandom_range(9, MAX_BYTES);
            send_message(len, MSG_RANDOM, zeros);
         end else if (roll < 88) begin
            // past capacity: the tail bytes are dropped
            len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
            send_message(len, MSG_RANDOM, zeros);
         end else if (roll < 94) begin
            send_message(MAX_BYTES, MSG_ALL_MAX, $urandom_range(0, 2));
         end else begin
            send_message($urandom_range(1, MAX_BYTES), MSG_ALL_ZERO, 0);
         end
         msg_no++;
         if (msg_no % 10 == 5) wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && symbols_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
